>>> src/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants for the sensor frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

   localparam int FrameBytes   = 17;
   localparam int PayloadDepth = 14;
   localparam int CountW       = 5;
   localparam int SlotW        = 4;
   localparam int CsrIdxW      = 1;
   localparam int CsrDataW     = 8;

   localparam logic [7:0]  HeaderFirstReset  = 8'h3C;
   localparam logic [7:0]  HeaderSecondReset = 8'h02;
   localparam logic [14:0] Centi             = 15'd100;
   localparam int          SignBit           = 7;

   // byte count codes
   localparam logic [CountW-1:0] CountHunt    = 5'd0;
   localparam logic [CountW-1:0] CountSecond  = 5'd1;
   localparam logic [CountW-1:0] CountPayload = 5'd2;
   localparam logic [CountW-1:0] CountLast    = 5'(FrameBytes - 1);

   // register indexes
   localparam logic [CsrIdxW-1:0] CsrHeaderFirst  = 1'b0;
   localparam logic [CsrIdxW-1:0] CsrHeaderSecond = 1'b1;

   // payload slots, frame byte n sits at slot n-2
   localparam int SlotEco2  = 0;
   localparam int SlotForm  = 2;
   localparam int SlotTvoc  = 4;
   localparam int SlotPm25  = 6;
   localparam int SlotPm10  = 8;
   localparam int SlotTemp  = 10;
   localparam int SlotHumid = 12;

   typedef struct packed {
      logic                         we;
      logic [CsrIdxW-1:0]           index;
      logic [CsrDataW-1:0]          wdata;
   } sfp_csr_type;

   typedef struct packed {
      logic                         last;
      logic                         checksum_ok;
      logic [CountW-1:0]            byte_count;
      logic [PayloadDepth-1:0][7:0] payload;
      logic [31:0]                  good_frames;
   } sfp_frame_type;

endpackage : sfp_pkg

`default_nettype wire

>>> src/sfp_if.sv
// ----------------------------------------------------------------------------
// sfp_if
// Valid/ready channels for received bytes and parsed frame results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface : sfp_req_if

interface sfp_rsp_if;
   logic               valid;
   logic               ready;
   logic               checksum_ok;
   logic [15:0]        eco2;
   logic [15:0]        formaldehyde;
   logic [15:0]        tvoc;
   logic [15:0]        pm25;
   logic [15:0]        pm10;
   logic signed [14:0] temperature_centi;
   logic [14:0]        humidity_centi;
   logic [31:0]        frame_number;

   modport source (output valid, output checksum_ok, output eco2, output formaldehyde,
                   output tvoc, output pm25, output pm10, output temperature_centi,
                   output humidity_centi, output frame_number, input ready);
   modport sink   (input valid, input checksum_ok, input eco2, input formaldehyde,
                   input tvoc, input pm25, input pm10, input temperature_centi,
                   input humidity_centi, input frame_number, output ready);
endinterface : sfp_rsp_if

`default_nettype wire

>>> src/sfp_frame_tracker.sv
// ----------------------------------------------------------------------------
// sfp_frame_tracker
// Header sync, byte count, running sum, payload bytes and good frame count.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_frame_tracker
   import sfp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic [7:0]    rx_byte,
   input  wire logic [7:0]    header_first,
   input  wire logic [7:0]    header_second,
   output sfp_frame_type      frame
);

   logic [CountW-1:0]            count_ff, count_in;
   logic [7:0]                   sum_ff, sum_in;
   logic [31:0]                  good_ff, good_in;
   logic [PayloadDepth-1:0][7:0] payload_ff;
   logic                         is_last;
   logic                         is_payload;
   logic                         sum_match;
   logic [SlotW-1:0]             slot;

   assign is_last    = (count_ff == CountLast);
   assign is_payload = (count_ff >= CountPayload) && (count_ff < CountLast);
   assign sum_match  = (sum_ff == rx_byte);
   assign slot       = SlotW'(count_ff - CountPayload);

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      good_in  = good_ff;
      if (step) begin
         priority if (count_ff == CountHunt) begin
            if (rx_byte == header_first) begin
               count_in = CountSecond;
               sum_in   = rx_byte;
            end
         end else if (count_ff == CountSecond) begin
            // a wrong second byte is dropped, not re-examined as a header
            if (rx_byte != header_second) begin
               count_in = CountHunt;
               sum_in   = 8'd0;
            end else begin
               count_in = CountPayload;
               sum_in   = sum_ff + rx_byte;
            end
         end else if (is_payload) begin
            count_in = count_ff + 5'd1;
            sum_in   = sum_ff + rx_byte;
         end else begin
            count_in = CountHunt;
            sum_in   = 8'd0;
            if (sum_match) begin
               good_in = good_ff + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountHunt;
         sum_ff   <= 8'd0;
         good_ff  <= 32'd0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         good_ff  <= good_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && is_payload) begin
         payload_ff[slot] <= rx_byte;
      end
   end

   assign frame.last        = is_last;
   assign frame.checksum_ok = sum_match;
   assign frame.byte_count  = count_ff;
   assign frame.payload     = payload_ff;
   assign frame.good_frames = good_ff;

endmodule : sfp_frame_tracker

`default_nettype wire

>>> src/sfp_result_stage.sv
// ----------------------------------------------------------------------------
// sfp_result_stage
// Scales the payload into readings and holds the result for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_result_stage
   import sfp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  sfp_frame_type      frame,
   output logic               out_free,
   sfp_rsp_if.source          rsp_if
);

   logic               valid_ff, valid_in;
   logic               ok_ff;
   logic [15:0]        eco2_ff, form_ff, tvoc_ff, pm25_ff, pm10_ff;
   logic signed [14:0] temp_ff;
   logic [14:0]        humid_ff;
   logic [31:0]        number_ff;

   logic [15:0]        eco2_in, form_in, tvoc_in, pm25_in, pm10_in;
   logic signed [14:0] temp_in;
   logic [14:0]        humid_in;
   logic [7:0]         t_int;
   logic [14:0]        t_mag;

   assign out_free = !valid_ff || rsp_if.ready;

   always_comb begin
      t_int    = frame.payload[SlotTemp];
      t_mag    = 15'(t_int[SignBit-1:0]) * Centi + 15'(frame.payload[SlotTemp+1]);
      eco2_in  = 16'd0;
      form_in  = 16'd0;
      tvoc_in  = 16'd0;
      pm25_in  = 16'd0;
      pm10_in  = 16'd0;
      temp_in  = 15'sd0;
      humid_in = 15'd0;
      // readings stay zero on a bad checksum
      if (frame.checksum_ok) begin
         eco2_in  = {frame.payload[SlotEco2], frame.payload[SlotEco2+1]};
         form_in  = {frame.payload[SlotForm], frame.payload[SlotForm+1]};
         tvoc_in  = {frame.payload[SlotTvoc], frame.payload[SlotTvoc+1]};
         pm25_in  = {frame.payload[SlotPm25], frame.payload[SlotPm25+1]};
         pm10_in  = {frame.payload[SlotPm10], frame.payload[SlotPm10+1]};
         temp_in  = t_int[SignBit] ? -$signed(t_mag) : $signed(t_mag);
         humid_in = 15'(frame.payload[SlotHumid]) * Centi
                  + 15'(frame.payload[SlotHumid+1]);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      priority if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ok_ff     <= frame.checksum_ok;
         eco2_ff   <= eco2_in;
         form_ff   <= form_in;
         tvoc_ff   <= tvoc_in;
         pm25_ff   <= pm25_in;
         pm10_ff   <= pm10_in;
         temp_ff   <= temp_in;
         humid_ff  <= humid_in;
         number_ff <= frame.good_frames;
      end
   end

   assign rsp_if.valid             = valid_ff;
   assign rsp_if.checksum_ok       = ok_ff;
   assign rsp_if.eco2              = eco2_ff;
   assign rsp_if.formaldehyde      = form_ff;
   assign rsp_if.tvoc              = tvoc_ff;
   assign rsp_if.pm25              = pm25_ff;
   assign rsp_if.pm10              = pm10_ff;
   assign rsp_if.temperature_centi = temp_ff;
   assign rsp_if.humidity_centi    = humid_ff;
   assign rsp_if.frame_number      = number_ff;

endmodule : sfp_result_stage

`default_nettype wire

>>> src/sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// sensor_frame_parser
// Byte-serial parser for a 17-byte sensor frame with additive checksum.
// ----------------------------------------------------------------------------
// path: a last byte moves from the input byte register to the output register
// throughput: 1 byte per cycle; one result per 17-byte frame, one result held
//   in the output register while the next bytes keep flowing; only a last byte
//   waits, and only while the previous result is still held
// reset: synchronous, clears byte count, sum, good frame count and valids;
//   headers return to 0x3C and 0x02
`default_nettype none

module sensor_frame_parser
   import sfp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  sfp_csr_type        csr_port,
   sfp_req_if.sink            req_if,
   sfp_rsp_if.source          rsp_if
);

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic [7:0]    header_first_ff, header_second_ff;
   logic          out_free;
   logic          step;
   logic          load;
   sfp_frame_type frame;

   // only the checksum byte needs a free output register
   assign step          = in_valid_ff && (out_free || !frame.last);
   assign load          = step && frame.last;
   assign req_if.ready  = !in_valid_ff || step;
   assign in_valid_in   = req_if.valid || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         header_first_ff  <= HeaderFirstReset;
         header_second_ff <= HeaderSecondReset;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_port.we) begin
            unique case (csr_port.index)
               CsrHeaderFirst:  header_first_ff  <= csr_port.wdata;
               CsrHeaderSecond: header_second_ff <= csr_port.wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.rx_byte;
      end
   end

   sfp_frame_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .rx_byte       (in_byte_ff),
      .header_first  (header_first_ff),
      .header_second (header_second_ff),
      .frame         (frame)
   );

   sfp_result_stage u_result (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .frame    (frame),
      .out_free (out_free),
      .rsp_if   (rsp_if)
   );

   // byte count never runs past the checksum byte
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      frame.byte_count <= CountLast)
      else $error("byte count out of range");

   // a result is only loaded into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_if.valid || rsp_if.ready))
      else $error("result overwritten before taken");

   // a good frame bumps the frame counter by exactly one
   a_good_count: assert property (@(posedge clock) disable iff (reset)
      (load && frame.checksum_ok) |=> frame.good_frames == $past(frame.good_frames) + 32'd1)
      else $error("good frame count did not advance");

   // a bad checksum result carries zero readings
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.checksum_ok) |-> (rsp_if.eco2 == 16'd0 &&
         rsp_if.pm10 == 16'd0 && rsp_if.temperature_centi == 15'sd0 &&
         rsp_if.humidity_centi == 15'd0))
      else $error("bad frame has nonzero readings");

endmodule : sensor_frame_parser

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor frame parser. Received bytes flow from a
// queue through a valid/ready driver. An in-bench frame parser predicts every
// frame result, and a monitor checks each result transaction in order. Header
// settings, sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sfp_pkg::*;

   typedef struct packed {
      logic        checksum_ok;
      logic [15:0] eco2;
      logic [15:0] formaldehyde;
      logic [15:0] tvoc;
      logic [15:0] pm25;
      logic [15:0] pm10;
      logic [14:0] temperature_centi;
      logic [14:0] humidity_centi;
      logic [31:0] frame_number;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   sfp_csr_type csr_port;

   sfp_req_if req_if ();
   sfp_rsp_if rsp_if ();

   sensor_frame_parser u_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_port (csr_port),
      .req_if   (req_if),
      .rsp_if   (rsp_if)
   );

   always #5 clock = ~clock;

   // stimulus and expectations
   logic [7:0]       pending_bytes[$];
   frame_result_type expected_frames[$];
   int               send_idle_pct;
   int               recv_stall_pct;
   int               mismatch_count = 0;

   // header settings, shared by the parser copy and the frame builder
   logic [7:0] hdr_first  = HeaderFirstReset;
   logic [7:0] hdr_second = HeaderSecondReset;

   // parser copy
   logic [CountW-1:0] frame_pos = CountHunt;
   logic [7:0]        frame_sum = '0;
   logic [7:0]        frame_payload[PayloadDepth];
   logic [31:0]       good_count = '0;

   task automatic queue_byte(input logic [7:0] data_byte);
      pending_bytes.insert(pending_bytes.size(), data_byte);
   endtask

   task automatic parse_byte(input logic [7:0] b);
      frame_result_type r;
      int               tmag;
      if (frame_pos == CountHunt) begin
         if (b == hdr_first) begin
            frame_sum = b;
            frame_pos = CountSecond;
         end
      end else if (frame_pos == CountSecond) begin
         if (b != hdr_second) begin
            frame_pos = CountHunt;
            frame_sum = '0;
         end else begin
            frame_sum = frame_sum + b;
            frame_pos = CountPayload;
         end
      end else if (frame_pos < CountLast) begin
         frame_payload[frame_pos - CountPayload] = b;
         frame_sum = frame_sum + b;
         frame_pos = frame_pos + 1'b1;
      end else begin
         r = '0;
         r.frame_number = good_count;
         if (frame_sum == b) begin
            r.checksum_ok  = 1'b1;
            r.eco2         = {frame_payload[SlotEco2], frame_payload[SlotEco2 + 1]};
            r.formaldehyde = {frame_payload[SlotForm], frame_payload[SlotForm + 1]};
            r.tvoc         = {frame_payload[SlotTvoc], frame_payload[SlotTvoc + 1]};
            r.pm25         = {frame_payload[SlotPm25], frame_payload[SlotPm25 + 1]};
            r.pm10         = {frame_payload[SlotPm10], frame_payload[SlotPm10 + 1]};
            tmag = int'(frame_payload[SlotTemp][6:0]) * int'(Centi)
                   + int'(frame_payload[SlotTemp + 1]);
            // sign-magnitude temperature, bit 7 of the integer byte
            r.temperature_centi = frame_payload[SlotTemp][SignBit] ? 15'(-tmag) : 15'(tmag);
            r.humidity_centi    = 15'(int'(frame_payload[SlotHumid]) * int'(Centi)
                                      + int'(frame_payload[SlotHumid + 1]));
            good_count = good_count + 1;
         end
         frame_pos = CountHunt;
         frame_sum = '0;
         expected_frames.insert(expected_frames.size(), r);
      end
   endtask

   function automatic string fmt_frame(frame_result_type r);
      return $sformatf("ok=%0d eco2=%h form=%h tvoc=%h pm25=%h pm10=%h temp=%0d hum=%0d num=%0d",
                       r.checksum_ok, r.eco2, r.formaldehyde, r.tvoc, r.pm25, r.pm10,
                       $signed(r.temperature_centi), r.humidity_centi, r.frame_number);
   endfunction

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.rx_byte <= '0;
      end else begin
         if (req_if.valid && req_if.ready) parse_byte(req_if.rx_byte);
         if (!req_if.valid || req_if.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_if.valid   <= 1'b1;
               req_if.rx_byte <= pending_bytes.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.checksum_ok, rsp_if.eco2, rsp_if.formaldehyde, rsp_if.tvoc,
                   rsp_if.pm25, rsp_if.pm10, rsp_if.temperature_centi,
                   rsp_if.humidity_centi, rsp_if.frame_number};
            if (expected_frames.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected frame result: %s", fmt_frame(got));
            end else begin
               want = expected_frames.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("frame result mismatch");
                     $display("  expected: %s", fmt_frame(want));
                     $display("  actual:   %s", fmt_frame(got));
                  end
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return hdr_first;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // fill < 0 gives random payload, otherwise every payload byte is fill
   task automatic push_frame(input int fill, input bit sum_good);
      logic [7:0] b;
      logic [7:0] sum;
      sum = hdr_first + hdr_second;
      queue_byte(hdr_first);
      queue_byte(hdr_second);
      for (int i = 2; i < FrameBytes - 1; i++) begin
         b = (fill < 0) ? pick_byte() : 8'(fill);
         sum = sum + b;
         queue_byte(b);
      end
      queue_byte(sum_good ? sum : 8'(sum + 8'($urandom_range(255, 1))));
   endtask

   task automatic fill_random(input int n);
      int         sent;
      int         k;
      logic [7:0] b;
      sent = 0;
      while (sent < n) begin
         case ($urandom_range(19))
            0: begin
               // line noise while hunting
               repeat ($urandom_range(4, 1))
                  queue_byte(hdr_first ^ 8'($urandom_range(255, 1)));
            end
            1: begin
               // wrong second byte, dropped even when it matches the first header
               if (hdr_first != hdr_second && $urandom_range(1)) b = hdr_first;
               else b = hdr_second ^ 8'($urandom_range(255, 1));
               queue_byte(hdr_first);
               queue_byte(b);
               sent += 2;
            end
            2: begin
               // cut-off frame, the following bytes get folded into it
               k = $urandom_range(12, 1);
               queue_byte(hdr_first);
               queue_byte(hdr_second);
               repeat (k) queue_byte(pick_byte());
               sent += k + 2;
            end
            3, 4: begin
               push_frame(-1, 1'b0);
               sent += FrameBytes;
            end
            default: begin
               push_frame(-1, 1'b1);
               sent += FrameBytes;
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_if.valid || expected_frames.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_headers(input logic [7:0] first, input logic [7:0] second);
      wait_drained();
      // let a trailing partial frame settle
      repeat (4) @(posedge clock);
      csr_port <= '{we: 1'b1, index: CsrHeaderFirst, wdata: first};
      @(posedge clock);
      csr_port <= '{we: 1'b1, index: CsrHeaderSecond, wdata: second};
      @(posedge clock);
      csr_port <= '{we: 1'b0, index: CsrHeaderFirst, wdata: '0};
      hdr_first  = first;
      hdr_second = second;
      @(negedge clock);
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;
      csr_port       = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: noise, repeated first header, full-scale good frame, zero bad frame
      queue_byte(hdr_first ^ 8'h01);
      queue_byte(hdr_first);
      queue_byte(hdr_first);
      push_frame(8'hFF, 1'b1);
      push_frame(8'h00, 1'b0);
      fill_random(290);

      set_headers(8'h00, 8'hFF);
      send_idle_pct = 85;
      fill_random(320);

      set_headers(8'hFF, 8'h00);
      send_idle_pct  = 0;
      recv_stall_pct = 85;
      fill_random(160);
      wait_drained();
      fill_random(160);

      set_headers(8'hA5, 8'hA5);
      send_idle_pct  = 29;
      recv_stall_pct = 29;
      fill_random(320);

      set_headers(8'($urandom_range(255)), 8'($urandom_range(255)));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fill_random(320);

      wait_drained();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && expected_frames.size() == 0)
         $display("** sensor_frame_parser: PASSED **");
      else
         $display("** sensor_frame_parser: FAILED **");
      $finish;
   end

   initial begin
      #5ms;
      $display("** sensor_frame_parser: FAILED **");
      $finish;
   end

endmodule : tb_top
